// ===== hdl/baro_pressure_temp_compensation_macros.svh =====
// Assertion macros for the barometric compensation block.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define BPC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpc: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpc: next-cycle check failed");
`else
`define BPC_ASSERT_IMPLY(lbl, ante, cons)
`define BPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/bpc_pkg.sv =====
// Widths, register indexes and constants of the barometric compensation block.
`default_nettype none
package bpc_pkg;

  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int TEMP_OUT_W = 19;
  localparam int PRES_W     = 24;
  localparam int REG_IDX_W  = 3;

  // internal datapath widths
  localparam int DT_W   = 25;  // D2 - C5*2^8
  localparam int MUL_W  = 42;  // dT times a coefficient
  localparam int DSQ_W  = 50;  // dT squared
  localparam int TEMP_W = 20;
  localparam int T2_W   = 18;
  localparam int OFF_W  = 40;
  localparam int SENS_W = 40;
  localparam int SQ_W   = 36;
  localparam int CORR_W = 40;
  localparam int SPLIT_W = 20; // low slice of SENS for the split multiply
  localparam int PL_W   = 44;
  localparam int PH_W   = 45;
  localparam int PROD_W = 64;
  localparam int DIFF_W = 44;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SENS         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SENS_TEMP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REF_TEMP     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_SLOPE   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_ORDER = 3'd6;

  // 20.00 degC and -15.00 degC
  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_DEEP = -20'sd1500;

  localparam logic [PRES_W-1:0] P_MAX = 24'hFFFFFF;

  typedef logic [RAW_W-1:0]  raw_t;
  typedef logic [COEF_W-1:0] coef_t;

endpackage
`default_nettype wire

// ===== hdl/bpc_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none
interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpc_sample_if.sv =====
// Input channel: one raw pressure and temperature conversion pair per item.
`default_nettype none
interface bpc_sample_if;
  import bpc_pkg::*;
  logic valid;
  logic ready;
  raw_t raw_pressure;
  raw_t raw_temperature;
  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpc_result_if.sv =====
// Output channel: compensated temperature and pressure per item.
`default_nettype none
interface bpc_result_if;
  import bpc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [TEMP_OUT_W-1:0] temperature_centi;
  logic [PRES_W-1:0]            pressure_centi_mbar;
  logic                         pressure_clamped;
  modport source (output valid, output temperature_centi, output pressure_centi_mbar,
                  output pressure_clamped, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_centi_mbar,
                  input pressure_clamped, output ready);
endinterface
`default_nettype wire

// ===== hdl/baro_pressure_temp_compensation.sv =====
// Top level: pipelined second-order barometric pressure and temperature compensation.
//
// Usage:
//   cfg    - write channel for the six calibration words (index 0..5) and the
//            second-order enable (index 6). Always ready; writes to other
//            indexes are dropped. Write only while no item is in flight.
//   sample - one raw pressure (D1) and raw temperature (D2) item per handshake.
//   result - temperature in 0.01 degC and pressure in 0.01 mbar; pressure is
//            clamped to 0..2^24-1 with pressure_clamped set when it was.
// Pipeline: ten register stages from the accepting edge to result.valid:
//   dT, coefficient products and dT^2, first-order terms, squares,
//   second-order terms, subtraction, split D1*SENS multiply, recombine,
//   offset, clamp.
// Throughput: one item per cycle unless result stalls. The widest product,
//   D1*SENS, is cut into two 24x20 partials so no multiplier is 24x40 wide.
// Stall: each stage holds while the next is full and stalled, so bubbles
//   close up and sample.ready stays high while any stage has room; a held
//   result does not block new items until the pipe is full.
// Reset: rst (synchronous) empties the pipe and clears the calibration words
//   and the enable to 0; datapath registers are not reset.
`default_nettype none
`include "baro_pressure_temp_compensation_macros.svh"
module baro_pressure_temp_compensation (
  input  logic          clk,
  input  logic          rst,
  bpc_cfg_if.sink       cfg,
  bpc_sample_if.sink    sample,
  bpc_result_if.source  result
);
  import bpc_pkg::*;

  localparam int NSTG = 10;

  // ---------------- configuration registers ----------------
  coef_t c1, c2, c3, c4, c5, c6;
  logic  so_en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1    <= '0;
      c2    <= '0;
      c3    <= '0;
      c4    <= '0;
      c5    <= '0;
      c6    <= '0;
      so_en <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SENS:         c1    <= cfg.data;
        REG_OFFSET:       c2    <= cfg.data;
        REG_SENS_TEMP:    c3    <= cfg.data;
        REG_OFFSET_TEMP:  c4    <= cfg.data;
        REG_REF_TEMP:     c5    <= cfg.data;
        REG_TEMP_SLOPE:   c6    <= cfg.data;
        REG_SECOND_ORDER: so_en <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  // A stage advances when it is empty or the stage after it advances.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vprev;
  logic [NSTG-1:0] ld;

  assign adv[NSTG-1] = !vld[NSTG-1] || result.ready;
  for (genvar k = 0; k < NSTG-1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end
  assign vprev = {vld[NSTG-2:0], sample.valid};
  assign ld    = adv & vprev;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~adv) | (vprev & adv);
    end
  end

  assign sample.ready = adv[0];
  assign result.valid = vld[NSTG-1];

  // ---------------- stage 0: dT ----------------
  raw_t                     d1_0, d1_1, d1_2, d1_3, d1_4, d1_5;
  logic signed [DT_W-1:0]   dt_0;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d1_0 <= sample.raw_pressure;
      dt_0 <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5, 8'b0});
    end
  end

  // ---------------- stage 1: coefficient products ----------------
  logic signed [MUL_W-1:0] mt_1, mo_1, ms_1;
  logic signed [DSQ_W-1:0] dd_1;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      d1_1 <= d1_0;
      mt_1 <= dt_0 * $signed({1'b0, c6});
      mo_1 <= dt_0 * $signed({1'b0, c4});
      ms_1 <= dt_0 * $signed({1'b0, c3});
      dd_1 <= dt_0 * dt_0;
    end
  end

  // ---------------- stage 2: first-order TEMP, OFF, SENS ----------------
  logic signed [TEMP_W-1:0] temp_2;
  logic signed [OFF_W-1:0]  off_2;
  logic signed [SENS_W-1:0] sens_2;
  logic [T2_W-1:0]          t2_2;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      d1_2   <= d1_1;
      temp_2 <= TEMP_REF + TEMP_W'(mt_1 >>> 23);
      off_2  <= $signed({8'b0, c2, 16'b0}) + OFF_W'(mo_1 >>> 7);
      sens_2 <= $signed({9'b0, c1, 15'b0}) + SENS_W'(ms_1 >>> 8);
      t2_2   <= dd_1[T2_W+30:31];   // dT^2 >> 31, never negative
    end
  end

  // ---------------- stage 3: squares and correction flags ----------------
  logic signed [TEMP_W-1:0]   lo_3, vl_3;
  logic signed [2*TEMP_W-1:0] lo_sq, vl_sq;
  logic                       corr_n;

  always_comb begin
    lo_3   = temp_2 - TEMP_REF;
    vl_3   = temp_2 - TEMP_DEEP;
    lo_sq  = lo_3 * lo_3;
    vl_sq  = vl_3 * vl_3;
    corr_n = so_en && (temp_2 < TEMP_REF);
  end

  logic signed [TEMP_W-1:0] tout_3, tout_4, tout_5, tout_6, tout_7, tout_8;
  logic signed [OFF_W-1:0]  off_3, off_4;
  logic signed [SENS_W-1:0] sens_3, sens_4;
  logic [SQ_W-1:0]          q_3, r_3;
  logic                     corr_3, deep_3;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      d1_3   <= d1_2;
      off_3  <= off_2;
      sens_3 <= sens_2;
      q_3    <= lo_sq[SQ_W-1:0];
      r_3    <= vl_sq[SQ_W-1:0];
      corr_3 <= corr_n;
      deep_3 <= temp_2 < TEMP_DEEP;
      tout_3 <= corr_n ? temp_2 - $signed({2'b0, t2_2}) : temp_2;
    end
  end

  // ---------------- stage 4: OFF2 and SENS2 ----------------
  logic [CORR_W-1:0] q5, r7, r11, off2_n, sens2_n;

  always_comb begin
    q5  = CORR_W'({q_3, 2'b00}) + CORR_W'(q_3);
    r7  = CORR_W'({r_3, 3'b000}) - CORR_W'(r_3);
    r11 = CORR_W'({r_3, 3'b000}) + CORR_W'({r_3, 1'b0}) + CORR_W'(r_3);
    off2_n  = '0;
    sens2_n = '0;
    if (corr_3) begin
      off2_n  = (q5 >> 1) + (deep_3 ? r7 : '0);
      sens2_n = (q5 >> 2) + (deep_3 ? (r11 >> 1) : '0);
    end
  end

  logic [CORR_W-1:0] off2_4, sens2_4;
  logic              corr_4;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      d1_4    <= d1_3;
      tout_4  <= tout_3;
      off_4   <= off_3;
      sens_4  <= sens_3;
      off2_4  <= off2_n;
      sens2_4 <= sens2_n;
      corr_4  <= corr_3;
    end
  end

  // ---------------- stage 5: corrected OFF and SENS ----------------
  logic signed [OFF_W-1:0]  offc_5, offc_6, offc_7;
  logic signed [SENS_W-1:0] sensc_5;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      d1_5    <= d1_4;
      tout_5  <= tout_4;
      offc_5  <= off_4 - $signed(off2_4);
      sensc_5 <= sens_4 - $signed(sens2_4);
    end
  end

  // ---------------- stage 6: D1*SENS partial products ----------------
  logic [PL_W-1:0]         pl_6;
  logic signed [PH_W-1:0]  ph_6;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      tout_6 <= tout_5;
      offc_6 <= offc_5;
      pl_6   <= d1_5 * sensc_5[SPLIT_W-1:0];
      ph_6   <= $signed({1'b0, d1_5}) * $signed(sensc_5[SENS_W-1:SPLIT_W]);
    end
  end

  // ---------------- stage 7: recombine product ----------------
  logic signed [PROD_W-1:0] prod_7;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      tout_7 <= tout_6;
      offc_7 <= offc_6;
      prod_7 <= (PROD_W'(ph_6) <<< SPLIT_W) + $signed({20'b0, pl_6});
    end
  end

  // ---------------- stage 8: subtract offset ----------------
  logic signed [DIFF_W-1:0] diff_8;

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      tout_8 <= tout_7;
      diff_8 <= DIFF_W'(prod_7 >>> 21) - DIFF_W'(offc_7);
    end
  end

  // ---------------- stage 9: scale, clamp, output register ----------------
  logic signed [DIFF_W-1:0] p_9;
  logic [PRES_W-1:0]        pres_n;
  logic                     clamp_n;

  always_comb begin
    p_9 = diff_8 >>> 15;
    if (p_9 < 0) begin
      pres_n  = '0;
      clamp_n = 1'b1;
    end else if (p_9 > $signed({20'b0, P_MAX})) begin
      pres_n  = P_MAX;
      clamp_n = 1'b1;
    end else begin
      pres_n  = p_9[PRES_W-1:0];
      clamp_n = 1'b0;
    end
  end

  logic signed [TEMP_OUT_W-1:0] temp_out;
  logic [PRES_W-1:0]            pres_out;
  logic                         clamp_out;

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      temp_out  <= tout_8[TEMP_OUT_W-1:0];
      pres_out  <= pres_n;
      clamp_out <= clamp_n;
    end
  end

  assign result.temperature_centi   = temp_out;
  assign result.pressure_centi_mbar = pres_out;
  assign result.pressure_clamped    = clamp_out;

  // ---------------- checks ----------------
  `BPC_ASSERT_NEXT(a_accept_enters, sample.valid && sample.ready, vld[0])
  `BPC_ASSERT_IMPLY(a_clamp_at_rail, result.valid && result.pressure_clamped, (result.pressure_centi_mbar == '0) || (result.pressure_centi_mbar == P_MAX))
  `BPC_ASSERT_IMPLY(a_warm_no_corr, vld[4] && !corr_4, (off2_4 == '0) && (sens2_4 == '0))
  `BPC_ASSERT_NEXT(a_stage_holds, vld[4] && !adv[4], vld[4] && $stable(sens2_4))

endmodule
`default_nettype wire
